/* hw/rtl/sobel_edge_magnitude_unit_macros.svh */
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_UNIT_MACROS_SVH

// A stalled transfer keeps valid high and its payload unchanged.
`define SEM_HOLD(label, clk, rst_n, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(sig))) \
        else $error("stalled transfer changed");

// Whenever the condition holds, the consequence holds in the same cycle.
`define SEM_CHECK(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |-> (cons)) \
        else $error("check failed");

`endif

/* hw/rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indices and types.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int MAG_W      = 21;
    localparam int ABS_W      = 10;   // |G| <= 1020
    localparam int SUM_W      = 10;   // p0 + 2*p1 + p2 <= 1020
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_WID_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_HGT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    localparam logic [MAG_W-1:0] MAG_MAX = 21'd2080800;

    // window[row][col], row 0 is the oldest line, col 2 the newest pixel
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic emit;   // interior position, a result follows
        logic last;   // last interior position of the frame
    } t_pos_info;

endpackage

/* hw/rtl/sem_raster_ctrl.sv */
// ----------------------------------------------------------------------------
// Sobel raster position control
// Configuration registers, frame size clamping and column/row counters.
// ----------------------------------------------------------------------------
module sem_raster_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int COL_W      = $clog2(MAX_WIDTH),
    parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_advance,
    output logic [COL_W-1:0]                o_col,
    output logic [COL_W-1:0]                o_next_col,
    output logic [COL_W-1:0]                o_ctr_col,
    output logic [ROW_W-1:0]                o_ctr_row,
    output sem_pkg::t_pos_info              o_info
);

    logic [sem_pkg::CFG_WID_W-1:0] r_cfg_width;
    logic [sem_pkg::CFG_HGT_W-1:0] r_cfg_height;
    logic [COL_W-1:0]              r_col, n_col;
    logic [ROW_W-1:0]              r_row, n_row;
    logic [COL_W-1:0]              w_last;
    logic [ROW_W-1:0]              h_last;
    logic [31:0]                   w_ext, h_ext;
    logic                          cfg_hit;
    logic                          col_end, row_end;

    assign cfg_hit = i_cfg_we && ((i_cfg_index == sem_pkg::CFG_IMAGE_WIDTH) ||
                                  (i_cfg_index == sem_pkg::CFG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= sem_pkg::RST_IMAGE_WIDTH;
            r_cfg_height <= sem_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_index == sem_pkg::CFG_IMAGE_WIDTH) begin
                r_cfg_width <= i_cfg_data[sem_pkg::CFG_WID_W-1:0];
            end
            if (i_cfg_index == sem_pkg::CFG_IMAGE_HEIGHT) begin
                r_cfg_height <= i_cfg_data[sem_pkg::CFG_HGT_W-1:0];
            end
        end
    end

    // clamp to 3..MAX, held as last index
    always_comb begin
        w_ext = 32'(r_cfg_width);
        h_ext = 32'(r_cfg_height);
        if (w_ext < 32'd3) begin
            w_last = COL_W'(2);
        end else if (w_ext > 32'(MAX_WIDTH)) begin
            w_last = COL_W'(MAX_WIDTH - 1);
        end else begin
            w_last = COL_W'(w_ext - 32'd1);
        end
        if (h_ext < 32'd3) begin
            h_last = ROW_W'(2);
        end else if (h_ext > 32'(MAX_HEIGHT)) begin
            h_last = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            h_last = ROW_W'(h_ext - 32'd1);
        end
    end

    assign col_end = (r_col >= w_last);
    assign row_end = (r_row >= h_last);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (i_advance) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col       = r_col;
    assign o_next_col  = n_col;
    assign o_ctr_col   = r_col - COL_W'(1);
    assign o_ctr_row   = r_row - ROW_W'(1);
    assign o_info.emit = (r_col >= COL_W'(2)) && (r_row >= ROW_W'(2));
    assign o_info.last = col_end && row_end;

endmodule

/* hw/rtl/sem_line_store.sv */
// ----------------------------------------------------------------------------
// Sobel line store
// Two previous rows kept as one memory word per column, registered read.
// ----------------------------------------------------------------------------
module sem_line_store #(
    parameter int MAX_WIDTH = 1024,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [COL_W-1:0]            i_waddr,
    input  logic [sem_pkg::PIX_W-1:0]   i_pixel,
    input  logic [COL_W-1:0]            i_raddr,
    output logic [sem_pkg::PIX_W-1:0]   o_prev1,   // row above
    output logic [sem_pkg::PIX_W-1:0]   o_prev2    // two rows above
);

    // word = {two rows above, row above}
    logic [2*sem_pkg::PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*sem_pkg::PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {r_rdata[sem_pkg::PIX_W-1:0], i_pixel};
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_prev1 = r_rdata[sem_pkg::PIX_W-1:0];
    assign o_prev2 = r_rdata[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];

endmodule

/* hw/rtl/sem_gradient.sv */
// ----------------------------------------------------------------------------
// Sobel gradient datapath
// Window to |Gx|,|Gy| stage, then squares and sum into the output register.
// ----------------------------------------------------------------------------
module sem_gradient #(
    parameter int COL_W = 10,
    parameter int ROW_W = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  sem_pkg::t_window            i_win,
    input  logic [COL_W-1:0]            i_col,
    input  logic [ROW_W-1:0]            i_row,
    input  logic                        i_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [sem_pkg::MAG_W-1:0]   o_magnitude,
    output logic [COL_W-1:0]            o_col,
    output logic [ROW_W-1:0]            o_row,
    output logic                        o_last
);

    localparam int DIF_W = sem_pkg::SUM_W + 2;

    logic [sem_pkg::SUM_W-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [DIF_W-1:0]   gx, gy;
    logic [sem_pkg::ABS_W-1:0] ax, ay;

    logic                      r_s2_valid;
    logic [sem_pkg::ABS_W-1:0] r_ax, r_ay;
    logic [COL_W-1:0]          r_s2_col;
    logic [ROW_W-1:0]          r_s2_row;
    logic                      r_s2_last;

    logic                      r_o_valid;
    logic [sem_pkg::MAG_W-1:0] r_mag;
    logic [COL_W-1:0]          r_o_col;
    logic [ROW_W-1:0]          r_o_row;
    logic                      r_o_last;

    logic                      out_ready, s2_ready;

    function automatic logic [sem_pkg::SUM_W-1:0] wsum(
        input logic [sem_pkg::PIX_W-1:0] a,
        input logic [sem_pkg::PIX_W-1:0] b,
        input logic [sem_pkg::PIX_W-1:0] c
    );
        return sem_pkg::SUM_W'(a) + (sem_pkg::SUM_W'(b) << 1) + sem_pkg::SUM_W'(c);
    endfunction

    always_comb begin
        gx_pos = wsum(i_win[0][2], i_win[1][2], i_win[2][2]);
        gx_neg = wsum(i_win[0][0], i_win[1][0], i_win[2][0]);
        gy_pos = wsum(i_win[0][0], i_win[0][1], i_win[0][2]);
        gy_neg = wsum(i_win[2][0], i_win[2][1], i_win[2][2]);
        gx     = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
        gy     = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
        ax     = sem_pkg::ABS_W'(gx < 0 ? -gx : gx);
        ay     = sem_pkg::ABS_W'(gy < 0 ? -gy : gy);
    end

    assign out_ready = !r_o_valid || i_ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign o_ready   = s2_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_ready) begin
                r_s2_valid <= i_valid;
            end
            if (out_ready) begin
                r_o_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && i_valid) begin
            r_ax      <= ax;
            r_ay      <= ay;
            r_s2_col  <= i_col;
            r_s2_row  <= i_row;
            r_s2_last <= i_last;
        end
        if (out_ready && r_s2_valid) begin
            r_mag    <= sem_pkg::MAG_W'(r_ax) * sem_pkg::MAG_W'(r_ax)
                      + sem_pkg::MAG_W'(r_ay) * sem_pkg::MAG_W'(r_ay);
            r_o_col  <= r_s2_col;
            r_o_row  <= r_s2_row;
            r_o_last <= r_s2_last;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_magnitude = r_mag;
    assign o_col       = r_o_col;
    assign o_row       = r_o_row;
    assign o_last      = r_o_last;

endmodule

/* hw/rtl/sobel_edge_magnitude_unit.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude unit
// Gx^2 + Gy^2 of the 3x3 Sobel kernels over a raster pixel stream.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------
//  pixel     in         i_valid / o_ready         i_pixel
//  result    out        o_valid / i_ready         o_magnitude, o_center_col,
//                                                 o_center_row, o_frame_last
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One pixel transfer per clock, sustained while results are taken. A result
//  passes the window, gradient and square-and-sum registers after the pixel
//  that completes its window. Line store read runs a column ahead.
//  Synchronous active-low reset clears counters, window and stage valids and
//  sets sizes to 640x480; the line store is left, rows 0 and 1 of each frame
//  refill it. A result-side stall fills all three stages before o_ready drops.
//
module sobel_edge_magnitude_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [sem_pkg::PIX_W-1:0]           i_pixel,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sem_pkg::MAG_W-1:0]           o_magnitude,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_center_col,
    output logic [$clog2(MAX_HEIGHT)-1:0]       o_center_row,
    output logic                                o_frame_last,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic                       accept;
    logic                       cfg_we;
    logic                       grad_ready;

    logic [COL_W-1:0]           col, next_col, ctr_col;
    logic [ROW_W-1:0]           ctr_row;
    sem_pkg::t_pos_info         info;
    logic [sem_pkg::PIX_W-1:0]  prev1, prev2;

    // window register doubles as the first pipeline stage
    sem_pkg::t_window           r_win, n_win;
    logic                       r_s1_valid;
    logic [COL_W-1:0]           r_s1_col;
    logic [ROW_W-1:0]           r_s1_row;
    logic                       r_s1_last;

    // configuration is always taken; the user must write only while idle, the block does not enforce it
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // the window may move only when its current contents have gone on
    assign o_ready = !r_s1_valid || grad_ready;
    assign accept  = i_valid && o_ready;

    sem_raster_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W)
    ) u_raster (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (accept),
        .o_col       (col),
        .o_next_col  (next_col),
        .o_ctr_col   (ctr_col),
        .o_ctr_row   (ctr_row),
        .o_info      (info)
    );

    // read runs at the column the next pixel will take; the write on a
    // transfer hits the current column, not the one being read unless a config write at column 0
    sem_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (col),
        .i_pixel (i_pixel),
        .i_raddr (next_col),
        .o_prev1 (prev1),
        .o_prev2 (prev2)
    );

    // shift left, new column enters at the right
    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = prev2;
        n_win[1][2] = prev1;
        n_win[2][2] = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_win      <= n_win;
            r_s1_valid <= info.emit;
        end else if (grad_ready) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col  <= ctr_col;
            r_s1_row  <= ctr_row;
            r_s1_last <= info.last;
        end
    end

    sem_gradient #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_s1_valid),
        .o_ready     (grad_ready),
        .i_win       (r_win),
        .i_col       (r_s1_col),
        .i_row       (r_s1_row),
        .i_last      (r_s1_last),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_magnitude (o_magnitude),
        .o_col       (o_center_col),
        .o_row       (o_center_row),
        .o_last      (o_frame_last)
    );

endmodule

/* hw/rtl/sem_checker.sv */
// ----------------------------------------------------------------------------
// Sobel edge magnitude checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sobel_edge_magnitude_unit_macros.svh"

module sem_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic [sem_pkg::MAG_W-1:0]           o_magnitude,
    input  logic [$clog2(MAX_WIDTH)-1:0]        o_center_col,
    input  logic [$clog2(MAX_HEIGHT)-1:0]       o_center_row,
    input  logic                                o_frame_last
);

    `SEM_HOLD(a_result_hold, i_clk, i_rst_n, o_valid, i_ready, {o_magnitude, o_center_col, o_center_row, o_frame_last})

    `SEM_CHECK(a_mag_bound, i_clk, i_rst_n, o_valid, o_magnitude <= sem_pkg::MAG_MAX)

    `SEM_CHECK(a_centre_interior, i_clk, i_rst_n, o_valid, (o_center_col != '0) && (o_center_row != '0))

endmodule

bind sobel_edge_magnitude_unit sem_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_sem_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_magnitude  (o_magnitude),
    .o_center_col (o_center_col),
    .o_center_row (o_center_row),
    .o_frame_last (o_frame_last)
);
